// ===== design/btfp_pkg.sv =====
// Package for the battery temperature fault policy block.
// Holds the payload and state types, reason codes and register indexes.
// No dependencies; every other design file imports it.
package btfp_pkg;

   // Fault reason codes
   localparam logic [3:0] RSN_NONE      = 4'd0;
   localparam logic [3:0] RSN_NOT_READY = 4'd1;
   localparam logic [3:0] RSN_PARTIAL   = 4'd2;
   localparam logic [3:0] RSN_STALE     = 4'd3;
   localparam logic [3:0] RSN_INVALID   = 4'd4;
   localparam logic [3:0] RSN_OPEN      = 4'd5;
   localparam logic [3:0] RSN_SHORT     = 4'd6;
   localparam logic [3:0] RSN_COLD_STOP = 4'd7;
   localparam logic [3:0] RSN_HOT_STOP  = 4'd8;
   localparam logic [3:0] RSN_FAN_MAX   = 4'd9;
   localparam logic [3:0] RSN_HARD      = 4'd10;
   localparam logic [3:0] RSN_SEVERE    = 4'd11;

   // Register indexes on the csr channel
   localparam int unsigned CsrIndexBits = 3;
   localparam logic [CsrIndexBits-1:0] CSR_SEVERE_LIMIT     = 3'd0;
   localparam logic [CsrIndexBits-1:0] CSR_HARD_LIMIT       = 3'd1;
   localparam logic [CsrIndexBits-1:0] CSR_FAN_MAX_LIMIT    = 3'd2;
   localparam logic [CsrIndexBits-1:0] CSR_CHARGE_MAX_LIMIT = 3'd3;
   localparam logic [CsrIndexBits-1:0] CSR_CHARGE_MIN_LIMIT = 3'd4;
   localparam logic [CsrIndexBits-1:0] CSR_SEVERE_CONFIRM   = 3'd5;
   localparam logic [CsrIndexBits-1:0] CSR_HARD_CONFIRM     = 3'd6;

   typedef struct packed {
      logic [CsrIndexBits-1:0] reg_index;
      logic [31:0]             wr_data;
   } csr_type;

   typedef struct packed {
      logic signed [15:0] severe_limit_deci_c;
      logic signed [15:0] hard_limit_deci_c;
      logic signed [15:0] fan_max_limit_deci_c;
      logic signed [15:0] charge_max_limit_deci_c;
      logic signed [15:0] charge_min_limit_deci_c;
      logic [31:0]        severe_confirm_ms;
      logic [31:0]        hard_confirm_ms;
   } cfg_type;

   typedef struct packed {
      logic               func;
      logic               data_present;
      logic               startup_complete;
      logic               full_usable;
      logic [4:0]         open_count;
      logic [4:0]         short_count;
      logic [4:0]         invalid_count;
      logic [4:0]         stale_count;
      logic signed [15:0] tmax_dc;
      logic signed [15:0] tmin_dc;
      logic [31:0]        period_ms;
   } req_type;

   typedef struct packed {
      logic       temp_ok;
      logic       scan_fault;
      logic       warning;
      logic       fan_max;
      logic       chg_inhibit;
      logic       ot_fault;
      logic       severe_fault;
      logic       confirmed;
      logic       latched;
      logic [3:0] fault_reason;
      logic [3:0] latch_rsn;
      logic       pending;
   } rsp_type;

   // Flags of the latest evaluation
   typedef struct packed {
      logic temp_ok;
      logic scan_fault;
      logic warning;
      logic fan_max;
      logic chg_inhibit;
      logic ot_fault;
      logic severe_fault;
      logic confirmed;
   } flags_type;

   // Policy state carried from one request to the next (timer kept apart)
   typedef struct packed {
      flags_type  flags;
      logic [3:0] reason;
      logic       latch;
      logic [3:0] latch_cause;
      logic       pend;
      logic [3:0] pend_tier;
   } state_type;

endpackage

// ===== design/btfp_if.sv =====
// Valid/ready channel interfaces for the request, response and csr ports.
// Depends on btfp_pkg for the payload types.
interface btfp_req_if import btfp_pkg::*; ();
   logic    valid;
   logic    ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface btfp_rsp_if import btfp_pkg::*; ();
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface btfp_csr_if import btfp_pkg::*; ();
   logic    valid;
   logic    ready;
   csr_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ===== design/btfp_csr.sv =====
// Threshold and confirm-time register file of the temperature fault policy.
// Depends on btfp_pkg and the csr channel interface.
module btfp_csr import btfp_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   btfp_csr_if.sink  csr_chan,
   output cfg_type   cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;
   logic    wr_en;

   // Writes are always taken
   assign csr_chan.ready = 1'b1;
   assign wr_en = csr_chan.valid;

   // Decode the register index; unknown indexes are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (csr_chan.data.reg_index)
            CSR_SEVERE_LIMIT:     cfg_in.severe_limit_deci_c     = csr_chan.data.wr_data[15:0];
            CSR_HARD_LIMIT:       cfg_in.hard_limit_deci_c       = csr_chan.data.wr_data[15:0];
            CSR_FAN_MAX_LIMIT:    cfg_in.fan_max_limit_deci_c    = csr_chan.data.wr_data[15:0];
            CSR_CHARGE_MAX_LIMIT: cfg_in.charge_max_limit_deci_c = csr_chan.data.wr_data[15:0];
            CSR_CHARGE_MIN_LIMIT: cfg_in.charge_min_limit_deci_c = csr_chan.data.wr_data[15:0];
            CSR_SEVERE_CONFIRM:   cfg_in.severe_confirm_ms       = csr_chan.data.wr_data;
            CSR_HARD_CONFIRM:     cfg_in.hard_confirm_ms         = csr_chan.data.wr_data;
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.severe_limit_deci_c     <= 16'sd650;
         cfg_ff.hard_limit_deci_c       <= 16'sd600;
         cfg_ff.fan_max_limit_deci_c    <= 16'sd550;
         cfg_ff.charge_max_limit_deci_c <= 16'sd450;
         cfg_ff.charge_min_limit_deci_c <= 16'sd0;
         cfg_ff.severe_confirm_ms       <= 32'd500;
         cfg_ff.hard_confirm_ms         <= 32'd1000;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== design/btfp_eval.sv =====
// Combinational policy evaluation: next state, pending timer and response.
// Depends on btfp_pkg.
module btfp_eval import btfp_pkg::*; #(
   parameter int unsigned TIMER_BITS = 32
) (
   input  cfg_type                cfg,
   input  req_type                item,
   input  state_type              cur_state,
   input  logic [TIMER_BITS-1:0]  cur_timer,
   output state_type              nxt_state,
   output logic [TIMER_BITS-1:0]  nxt_timer,
   output rsp_type                result
);

   localparam logic [32:0] TimerTop = (33'd1 << TIMER_BITS) - 33'd1;

   logic                  at_severe;
   logic                  at_hard;
   logic [3:0]            hot_tier;
   logic [31:0]           hot_confirm;
   logic [TIMER_BITS-1:0] timer_base;
   logic [32:0]           timer_sum;
   logic [TIMER_BITS-1:0] timer_sat;
   logic                  confirm_hit;

   // Overtemperature tier and saturating pending timer
   always_comb begin
      at_severe   = item.tmax_dc >= cfg.severe_limit_deci_c;
      at_hard     = item.tmax_dc >= cfg.hard_limit_deci_c;
      hot_tier    = at_severe ? RSN_SEVERE : RSN_HARD;
      hot_confirm = at_severe ? cfg.severe_confirm_ms : cfg.hard_confirm_ms;
      timer_base  = (cur_state.pend_tier != hot_tier) ? '0 : cur_timer;
      timer_sum   = 33'(timer_base) + 33'(item.period_ms);
      timer_sat   = (timer_sum > TimerTop) ? TimerTop[TIMER_BITS-1:0]
                                           : timer_sum[TIMER_BITS-1:0];
      confirm_hit = 33'(timer_sat) >= 33'(hot_confirm);
   end

   // Next policy state
   always_comb begin
      nxt_state = cur_state;
      nxt_timer = cur_timer;
      if (item.func) begin
         // Reset-latch request: clear latch and pending, drop confirmation
         nxt_state.latch       = 1'b0;
         nxt_state.latch_cause = RSN_NONE;
         if (cur_state.flags.confirmed) begin
            nxt_state.flags.confirmed = 1'b0;
            nxt_state.reason          = RSN_NONE;
         end
         nxt_state.pend      = 1'b0;
         nxt_state.pend_tier = RSN_NONE;
         nxt_timer           = '0;
      end else begin
         nxt_state.flags  = '0;
         nxt_state.reason = RSN_NONE;
         priority if (!item.data_present || !item.startup_complete) begin
            nxt_state.flags.scan_fault = 1'b1;
            nxt_state.flags.confirmed  = 1'b1;
            nxt_state.flags.fan_max    = 1'b1;
            nxt_state.reason           = RSN_NOT_READY;
            nxt_state.pend             = 1'b0;
            nxt_state.pend_tier        = RSN_NONE;
            nxt_timer                  = '0;
         end else if (!item.full_usable) begin
            nxt_state.flags.scan_fault = 1'b1;
            nxt_state.flags.confirmed  = 1'b1;
            nxt_state.flags.fan_max    = 1'b1;
            nxt_state.pend             = 1'b0;
            nxt_state.pend_tier        = RSN_NONE;
            nxt_timer                  = '0;
            priority if (item.open_count != '0)    nxt_state.reason = RSN_OPEN;
            else if (item.short_count != '0)       nxt_state.reason = RSN_SHORT;
            else if (item.invalid_count != '0)     nxt_state.reason = RSN_INVALID;
            else if (item.stale_count != '0)       nxt_state.reason = RSN_STALE;
            else                                   nxt_state.reason = RSN_PARTIAL;
         end else if (at_severe || at_hard) begin
            // Hard or severe overtemperature sets pending and latches once confirmed
            nxt_state.flags.temp_ok    = 1'b1;
            nxt_state.flags.warning    = 1'b1;
            nxt_state.flags.fan_max    = 1'b1;
            nxt_state.pend             = 1'b1;
            nxt_state.pend_tier        = hot_tier;
            nxt_state.reason           = hot_tier;
            nxt_timer                  = timer_sat;
            if (confirm_hit) begin
               nxt_state.flags.ot_fault     = 1'b1;
               nxt_state.flags.confirmed    = 1'b1;
               nxt_state.flags.severe_fault = at_severe;
               nxt_state.latch              = 1'b1;
               nxt_state.latch_cause        = hot_tier;
            end
         end else begin
            nxt_state.flags.temp_ok    = 1'b1;
            nxt_state.pend             = 1'b0;
            nxt_state.pend_tier        = RSN_NONE;
            nxt_timer                  = '0;
            priority if (item.tmax_dc >= cfg.fan_max_limit_deci_c) begin
               nxt_state.flags.fan_max     = 1'b1;
               nxt_state.flags.chg_inhibit = 1'b1;
               nxt_state.flags.warning     = 1'b1;
               nxt_state.reason            = RSN_FAN_MAX;
            end else if (item.tmax_dc >= cfg.charge_max_limit_deci_c) begin
               nxt_state.flags.chg_inhibit = 1'b1;
               nxt_state.flags.warning     = 1'b1;
               nxt_state.reason            = RSN_HOT_STOP;
            end else if (item.tmin_dc <= cfg.charge_min_limit_deci_c) begin
               nxt_state.flags.chg_inhibit = 1'b1;
               nxt_state.flags.warning     = 1'b1;
               nxt_state.reason            = RSN_COLD_STOP;
            end else begin
               nxt_state.reason = RSN_NONE;
            end
         end
      end
   end

   // Response fields come straight from the updated state
   always_comb begin
      result.temp_ok      = nxt_state.flags.temp_ok;
      result.scan_fault   = nxt_state.flags.scan_fault;
      result.warning      = nxt_state.flags.warning;
      result.fan_max      = nxt_state.flags.fan_max;
      result.chg_inhibit  = nxt_state.flags.chg_inhibit;
      result.ot_fault     = nxt_state.flags.ot_fault;
      result.severe_fault = nxt_state.flags.severe_fault;
      result.confirmed    = nxt_state.flags.confirmed;
      result.latched      = nxt_state.latch;
      result.fault_reason = nxt_state.reason;
      result.latch_rsn    = nxt_state.latch_cause;
      result.pending      = nxt_state.pend;
   end

endmodule

// ===== design/battery_temperature_fault_policy_core.sv =====
// Top level of the battery temperature fault policy block.
// Depends on btfp_pkg, the channel interfaces, btfp_csr and btfp_eval.
//
// Takes one request per clock unless responses stall, and returns one
// response per request, in order. A request lands in an input register; the
// policy is evaluated from it and the stored state in one pass; once the
// output register is free, the state is updated and the response is written
// to the output register. Throughput is one request per cycle while responses
// are accepted, set by the single evaluation pass between the input and output
// registers; a stalled response holds one request in the input register while
// the next waits. The user writes thresholds and confirm times on the csr
// channel while idle; the block does not enforce this.
module battery_temperature_fault_policy_core import btfp_pkg::*; #(
   parameter int unsigned TIMER_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   btfp_req_if.sink    req_chan,
   btfp_rsp_if.source  rsp_chan,
   btfp_csr_if.sink    csr_chan
);

   cfg_type               cfg;
   logic                  s1_valid_ff;
   req_type               s1_data_ff;
   logic                  rsp_valid_ff;
   rsp_type               rsp_data_ff;
   state_type             state_ff;
   state_type             state_in;
   logic [TIMER_BITS-1:0] timer_ff;
   logic [TIMER_BITS-1:0] timer_in;
   rsp_type               result;
   logic                  advance;
   logic                  req_take;

   btfp_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .csr_chan (csr_chan),
      .cfg      (cfg)
   );

   btfp_eval #(.TIMER_BITS(TIMER_BITS)) u_eval (
      .cfg       (cfg),
      .item      (s1_data_ff),
      .cur_state (state_ff),
      .cur_timer (timer_ff),
      .nxt_state (state_in),
      .nxt_timer (timer_in),
      .result    (result)
   );

   // Handshake: input register moves on when the output register is free
   assign advance        = s1_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !s1_valid_ff || advance;
   assign req_take       = req_chan.valid && req_chan.ready;

   // Control and policy state
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= '{flags: '0, reason: RSN_NOT_READY, latch: 1'b0,
                           latch_cause: RSN_NONE, pend: 1'b0, pend_tier: RSN_NONE};
         timer_ff     <= '0;
      end else begin
         if (req_take) begin
            s1_valid_ff <= 1'b1;
         end else if (advance) begin
            s1_valid_ff <= 1'b0;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
            state_ff     <= state_in;
            timer_ff     <= timer_in;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_data_ff <= req_chan.data;
      end
      if (advance) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.data  = rsp_data_ff;

   // A latched fault always carries a hard or severe cause, and only then
   a_latch_cause : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff.latched == (rsp_data_ff.latch_rsn != RSN_NONE)))
      else $error("latched reason disagrees with latch");

   // Pending only on a usable scan
   a_pend_valid : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.pending |->
         rsp_data_ff.temp_ok && !rsp_data_ff.scan_fault)
      else $error("pending set without a usable scan");

   // A reset-latch request leaves latch and pending cleared
   a_latch_clear : assert property (@(posedge clock) disable iff (reset)
      advance && s1_data_ff.func |=> !state_ff.latch && !state_ff.pend && (timer_ff == '0))
      else $error("reset-latch did not clear latch state");

   // Severe fault always comes with an overtemperature fault
   a_severe : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.severe_fault |-> rsp_data_ff.ot_fault)
      else $error("severe fault without overtemperature");

endmodule

// ===== dv/battery_temperature_fault_policy_core_test.sv =====
// Self-checking testbench for battery_temperature_fault_policy_core.
// Depends on btfp_pkg and the channel interfaces in btfp_if.sv. It predicts
// every response from its own copy of the fault policy and compares fields.
module battery_temperature_fault_policy_core_test;
   import btfp_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned TimerBits = 32;
   localparam int CycleLimit = 400000;

   // Request function codes
   localparam logic FUNC_EVALUATE    = 1'b0;
   localparam logic FUNC_CLEAR_LATCH = 1'b1;

   logic clock;
   logic reset;

   btfp_req_if req_chan();
   btfp_rsp_if rsp_chan();
   btfp_csr_if csr_chan();

   battery_temperature_fault_policy_core #(.TIMER_BITS(TimerBits)) u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   // Mirror of the thresholds and confirm times
   cfg_type cfg_model;

   // Mirror of the policy state
   flags_type       pol_flags;
   logic [3:0]      pol_reason;
   logic            pol_latch;
   logic [3:0]      pol_latch_cause;
   logic            pol_pend;
   logic [3:0]      pol_tier;
   longint unsigned pol_timer;

   req_type scan_q[$];      // requests waiting to be driven
   rsp_type verdict_q[$];   // predicted responses, oldest first

   int  scans_sent;
   int  scans_taken;
   int  fail_count;
   int  cycle_count;
   bit  quiet_run;          // no idling on either side while set
   int  hold_asked;
   int  hold_served;
   int  hot_run_left;
   logic signed [15:0] hot_run_temp;

   // ------------------------------------------------------------------
   // Policy predictor
   // ------------------------------------------------------------------
   function automatic void drop_pend();
      pol_pend  = 1'b0;
      pol_tier  = RSN_NONE;
      pol_timer = 0;
   endfunction

   // Severe or hard tier: accumulate the timer and latch once confirmed
   function automatic void track_overtemp(logic [3:0] tier, logic [31:0] confirm,
                                          logic [31:0] period);
      longint unsigned top;
      top = (64'd1 << TimerBits) - 1;
      pol_flags.warning = 1'b1;
      pol_flags.fan_max = 1'b1;
      pol_pend   = 1'b1;
      pol_reason = tier;
      if (pol_tier != tier) begin
         pol_tier  = tier;
         pol_timer = 0;
      end
      if (longint'(period) > top - pol_timer) pol_timer = top;
      else pol_timer = pol_timer + period;
      if (pol_timer >= longint'(confirm)) begin
         pol_flags.ot_fault  = 1'b1;
         pol_flags.confirmed = 1'b1;
         if (tier == RSN_SEVERE) pol_flags.severe_fault = 1'b1;
         pol_latch       = 1'b1;
         pol_latch_cause = tier;
      end
   endfunction

   function automatic rsp_type judge_scan(req_type r);
      rsp_type v;
      logic signed [15:0] tmax;
      logic signed [15:0] tmin;
      tmax = r.tmax_dc;
      tmin = r.tmin_dc;
      if (r.func == FUNC_CLEAR_LATCH) begin
         pol_latch       = 1'b0;
         pol_latch_cause = RSN_NONE;
         if (pol_flags.confirmed) begin
            pol_flags.confirmed = 1'b0;
            pol_reason          = RSN_NONE;
         end
         drop_pend();
      end else begin
         pol_flags  = '0;
         pol_reason = RSN_NONE;
         if (!r.data_present || !r.startup_complete || !r.full_usable) begin
            // read fault: latch is kept, pending is dropped
            pol_flags.scan_fault = 1'b1;
            pol_flags.confirmed  = 1'b1;
            pol_flags.fan_max    = 1'b1;
            drop_pend();
            if (!r.data_present || !r.startup_complete) pol_reason = RSN_NOT_READY;
            else if (r.open_count != 0)    pol_reason = RSN_OPEN;
            else if (r.short_count != 0)   pol_reason = RSN_SHORT;
            else if (r.invalid_count != 0) pol_reason = RSN_INVALID;
            else if (r.stale_count != 0)   pol_reason = RSN_STALE;
            else pol_reason = RSN_PARTIAL;
         end else begin
            pol_flags.temp_ok = 1'b1;
            if (tmax >= $signed(cfg_model.severe_limit_deci_c)) begin
               track_overtemp(RSN_SEVERE, cfg_model.severe_confirm_ms, r.period_ms);
            end else if (tmax >= $signed(cfg_model.hard_limit_deci_c)) begin
               track_overtemp(RSN_HARD, cfg_model.hard_confirm_ms, r.period_ms);
            end else begin
               drop_pend();
               if (tmax >= $signed(cfg_model.fan_max_limit_deci_c)) begin
                  pol_flags.fan_max     = 1'b1;
                  pol_flags.chg_inhibit = 1'b1;
                  pol_flags.warning     = 1'b1;
                  pol_reason = RSN_FAN_MAX;
               end else if (tmax >= $signed(cfg_model.charge_max_limit_deci_c)) begin
                  pol_flags.chg_inhibit = 1'b1;
                  pol_flags.warning     = 1'b1;
                  pol_reason = RSN_HOT_STOP;
               end else if (tmin <= $signed(cfg_model.charge_min_limit_deci_c)) begin
                  pol_flags.chg_inhibit = 1'b1;
                  pol_flags.warning     = 1'b1;
                  pol_reason = RSN_COLD_STOP;
               end
            end
         end
      end
      v.temp_ok      = pol_flags.temp_ok;
      v.scan_fault   = pol_flags.scan_fault;
      v.warning      = pol_flags.warning;
      v.fan_max      = pol_flags.fan_max;
      v.chg_inhibit  = pol_flags.chg_inhibit;
      v.ot_fault     = pol_flags.ot_fault;
      v.severe_fault = pol_flags.severe_fault;
      v.confirmed    = pol_flags.confirmed;
      v.latched      = pol_latch;
      v.fault_reason = pol_reason;
      v.latch_rsn    = pol_latch_cause;
      v.pending      = pol_pend;
      return v;
   endfunction

   // ------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------
   // Mostly back to back, some short gaps, a few long ones
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (quiet_run || r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic void queue_scan(req_type s);
      scan_q.push_back(s);
      scans_sent++;
   endfunction

   // health = {data_present, startup_complete, full_usable}
   function automatic req_type scan(logic [2:0] health, int open_n, int short_n,
                                    int invalid_n, int stale_n, int tmax, int tmin,
                                    logic [31:0] period);
      req_type s;
      s.func = FUNC_EVALUATE;
      {s.data_present, s.startup_complete, s.full_usable} = health;
      s.open_count    = 5'(open_n);
      s.short_count   = 5'(short_n);
      s.invalid_count = 5'(invalid_n);
      s.stale_count   = 5'(stale_n);
      s.tmax_dc       = 16'(tmax);
      s.tmin_dc       = 16'(tmin);
      s.period_ms     = period;
      return s;
   endfunction

   // Clear-latch request with junk in every ignored field
   function automatic req_type latch_reset();
      req_type s;
      logic [95:0] junk;
      junk = {$urandom, $urandom, $urandom};
      s = junk[$bits(req_type)-1:0];
      s.func = FUNC_CLEAR_LATCH;
      return s;
   endfunction

   // A temperature a few tenths either side of a limit, clamped to 16 bits
   function automatic logic [15:0] nudge(logic signed [15:0] lim);
      int t;
      t = int'(lim) + int'($urandom_range(0, 6)) - 3;
      if (t > 32767) t = 32767;
      if (t < -32768) t = -32768;
      return 16'(t);
   endfunction

   function automatic req_type random_scan();
      req_type s;
      int pick;
      logic signed [15:0] lim;
      logic [95:0] junk;
      junk = {$urandom, $urandom, $urandom};
      s = junk[$bits(req_type)-1:0];
      s.func = FUNC_EVALUATE;
      s.open_count    = 5'($urandom_range(0, 24));
      s.short_count   = 5'($urandom_range(0, 24));
      s.invalid_count = 5'($urandom_range(0, 24));
      s.stale_count   = 5'($urandom_range(0, 24));
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
         s = latch_reset();
      end else if (pick < 20) begin
         // broken scan: at least one health flag low, reasons spread out
         {s.data_present, s.startup_complete, s.full_usable} = 3'($urandom_range(0, 6));
         if ($urandom_range(0, 9) < 6) s.open_count = 0;
         if ($urandom_range(0, 9) < 6) s.short_count = 0;
         if ($urandom_range(0, 9) < 6) s.invalid_count = 0;
         if ($urandom_range(0, 9) < 6) s.stale_count = 0;
      end else begin
         s.data_present     = 1'b1;
         s.startup_complete = 1'b1;
         s.full_usable      = 1'b1;
         if (hot_run_left > 0) begin
            // same tier again so the timer can build up
            hot_run_left--;
            s.tmax_dc = hot_run_temp;
         end else begin
            case ($urandom_range(0, 4))
               0: lim = cfg_model.severe_limit_deci_c;
               1: lim = cfg_model.hard_limit_deci_c;
               2: lim = cfg_model.fan_max_limit_deci_c;
               3: lim = cfg_model.charge_max_limit_deci_c;
               default: lim = cfg_model.charge_min_limit_deci_c;
            endcase
            pick = $urandom_range(0, 9);
            if (pick < 6) s.tmax_dc = nudge(lim);
            else if (pick < 8) s.tmax_dc = 16'(int'($urandom_range(0, 1200)) - 400);
            if ($urandom_range(0, 3) == 0) begin
               hot_run_left = $urandom_range(3, 12);
               hot_run_temp = s.tmax_dc;
            end
         end
         if ($urandom_range(0, 1) == 0) s.tmin_dc = nudge(cfg_model.charge_min_limit_deci_c);
         pick = $urandom_range(0, 9);
         if (pick < 7) s.period_ms = $urandom_range(0, 120);
         else if (pick < 8) s.period_ms = '0;
         else if (pick < 9) s.period_ms = 32'hFFFF_FFFF - $urandom_range(0, 200);
      end
      return s;
   endfunction

   // Wait until every request is taken and every response has come back
   task automatic wait_idle();
      while (scans_taken != scans_sent || verdict_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(logic [CsrIndexBits-1:0] idx, logic [31:0] val);
      @(posedge clock);
      csr_chan.valid <= 1'b1;
      csr_chan.data  <= '{reg_index: idx, wr_data: val};
      do @(posedge clock); while (!csr_chan.ready);
      csr_chan.valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic load_limits(logic [15:0] severe, logic [15:0] hard, logic [15:0] fan,
                              logic [15:0] cmax, logic [15:0] cmin,
                              logic [31:0] sconf, logic [31:0] hconf);
      write_csr(CSR_SEVERE_LIMIT,     {16'h0, severe});
      write_csr(CSR_HARD_LIMIT,       {16'h0, hard});
      write_csr(CSR_FAN_MAX_LIMIT,    {16'h0, fan});
      write_csr(CSR_CHARGE_MAX_LIMIT, {16'h0, cmax});
      write_csr(CSR_CHARGE_MIN_LIMIT, {16'h0, cmin});
      write_csr(CSR_SEVERE_CONFIRM,   sconf);
      write_csr(CSR_HARD_CONFIRM,     hconf);
   endtask

   // Random requests in chunks; some chunks end with the sender pausing
   // until every response is back, one can open with a long receiver hold.
   task automatic run_scans(int total, bit with_hold);
      int i;
      for (i = 0; i < total; i++) begin
         if (i % 25 == 0) begin
            while (scans_taken != scans_sent) @(posedge clock);
            if ($urandom_range(0, 2) == 0) wait_idle();
            quiet_run = ($urandom_range(0, 3) == 0);
            if (with_hold && i == 0) hold_asked++;
         end
         queue_scan(random_scan());
      end
      wait_idle();
   endtask

   // ------------------------------------------------------------------
   // Clock, cycle limit
   // ------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("** battery_temperature_fault_policy_core: FAILED **");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Request driver and predictor hook
   // ------------------------------------------------------------------
   int gap_left;

   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
         gap_left = 0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            verdict_q.push_back(judge_scan(req_chan.data));
            scans_taken++;
         end
         if (!req_chan.valid || req_chan.ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_chan.valid <= 1'b0;
            end else if (scan_q.size() != 0) begin
               req_chan.data  <= scan_q.pop_front();
               req_chan.valid <= 1'b1;
               gap_left = pick_gap();
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // Register writes update the mirror when taken
   always @(posedge clock) begin
      if (!reset && csr_chan.valid && csr_chan.ready) begin
         case (csr_chan.data.reg_index)
            CSR_SEVERE_LIMIT:     cfg_model.severe_limit_deci_c = csr_chan.data.wr_data[15:0];
            CSR_HARD_LIMIT:       cfg_model.hard_limit_deci_c = csr_chan.data.wr_data[15:0];
            CSR_FAN_MAX_LIMIT:    cfg_model.fan_max_limit_deci_c = csr_chan.data.wr_data[15:0];
            CSR_CHARGE_MAX_LIMIT: cfg_model.charge_max_limit_deci_c = csr_chan.data.wr_data[15:0];
            CSR_CHARGE_MIN_LIMIT: cfg_model.charge_min_limit_deci_c = csr_chan.data.wr_data[15:0];
            CSR_SEVERE_CONFIRM:   cfg_model.severe_confirm_ms = csr_chan.data.wr_data;
            CSR_HARD_CONFIRM:     cfg_model.hard_confirm_ms = csr_chan.data.wr_data;
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------------------
   // Response side: random stalls plus an occasional long hold
   // ------------------------------------------------------------------
   int stall_left;

   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         stall_left = 0;
      end else if (hold_served != hold_asked) begin
         hold_served = hold_asked;
         stall_left  = 150;
         rsp_chan.ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_chan.ready <= 1'b0;
      end else begin
         stall_left = pick_gap();
         rsp_chan.ready <= (stall_left == 0);
         if (stall_left > 0) stall_left--;
      end
   end

   function automatic void compare_field(string name, logic [3:0] want, logic [3:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      rsp_type got;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got = rsp_chan.data;
         if (verdict_q.size() == 0) begin
            $error("response with no request outstanding");
            fail_count++;
         end else begin
            want = verdict_q.pop_front();
            compare_field("temp_ok",      4'(want.temp_ok),      4'(got.temp_ok));
            compare_field("scan_fault",   4'(want.scan_fault),   4'(got.scan_fault));
            compare_field("warning",      4'(want.warning),      4'(got.warning));
            compare_field("fan_max",      4'(want.fan_max),      4'(got.fan_max));
            compare_field("chg_inhibit",  4'(want.chg_inhibit),  4'(got.chg_inhibit));
            compare_field("ot_fault",     4'(want.ot_fault),     4'(got.ot_fault));
            compare_field("severe_fault", 4'(want.severe_fault), 4'(got.severe_fault));
            compare_field("confirmed",    4'(want.confirmed),    4'(got.confirmed));
            compare_field("latched",      4'(want.latched),      4'(got.latched));
            compare_field("fault_reason", want.fault_reason,     got.fault_reason);
            compare_field("latch_rsn",    want.latch_rsn,        got.latch_rsn);
            compare_field("pending",      4'(want.pending),      4'(got.pending));
         end
      end
   end

   // ------------------------------------------------------------------
   // Test sequence
   // ------------------------------------------------------------------
   initial begin
      reset          = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.data  = '0;
      rsp_chan.ready = 1'b0;
      csr_chan.valid = 1'b0;
      csr_chan.data  = '0;
      cfg_model = '{severe_limit_deci_c: 16'sd650, hard_limit_deci_c: 16'sd600,
                    fan_max_limit_deci_c: 16'sd550, charge_max_limit_deci_c: 16'sd450,
                    charge_min_limit_deci_c: 16'sd0, severe_confirm_ms: 32'd500,
                    hard_confirm_ms: 32'd1000};
      pol_flags       = '0;
      pol_reason      = RSN_NOT_READY;
      pol_latch       = 1'b0;
      pol_latch_cause = RSN_NONE;
      drop_pend();
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed pass on the reset thresholds
      queue_scan(scan(3'b011, 3, 0, 0, 0, 200, 100, 10));        // no data
      queue_scan(scan(3'b101, 24, 24, 24, 24, 200, 100, 10));    // startup incomplete
      queue_scan(scan(3'b110, 24, 24, 24, 24, 200, 100, 10));    // open wins
      queue_scan(scan(3'b110, 0, 17, 1, 1, 200, 100, 10));       // short
      queue_scan(scan(3'b110, 0, 0, 24, 3, 200, 100, 10));       // invalid
      queue_scan(scan(3'b110, 0, 0, 0, 1, 200, 100, 10));        // stale
      queue_scan(scan(3'b110, 0, 0, 0, 0, 200, 100, 10));        // partial
      queue_scan(scan(3'b111, 0, 0, 0, 0, 200, 100, 10));        // all clear
      queue_scan(scan(3'b111, 0, 0, 0, 0, 200, 0, 10));          // cold at limit
      queue_scan(scan(3'b111, 0, 0, 0, 0, 450, 100, 10));        // hot stop
      queue_scan(scan(3'b111, 0, 0, 0, 0, 550, 100, 10));        // fan max
      queue_scan(scan(3'b111, 0, 0, 0, 0, 600, 100, 400));       // hard pends
      queue_scan(scan(3'b111, 0, 0, 0, 0, 649, 100, 700));       // hard latches
      queue_scan(scan(3'b111, 0, 0, 0, 0, 650, 100, 100));       // tier change
      queue_scan(scan(3'b111, 0, 0, 0, 0, 700, 100, 400));       // severe latches
      queue_scan(latch_reset());                                 // clears confirmed
      queue_scan(latch_reset());                                 // nothing confirmed
      queue_scan(scan(3'b111, 31, 31, 31, 31, 32767, 100, 32'hFFFF_FFFF));
      queue_scan(scan(3'b111, 0, 0, 0, 0, 32767, 100, 32'hFFFF_FFFF)); // saturated
      queue_scan(scan(3'b011, 0, 0, 0, 0, 32767, 100, 10));      // read fault, latch stays
      queue_scan(latch_reset());
      queue_scan(scan(3'b111, 0, 0, 0, 0, -32768, -32768, 5));   // cold extreme
      queue_scan(scan(3'b111, 0, 0, 0, 0, 32767, 32767, 0));     // severe, zero period
      queue_scan(scan(3'b111, 0, 0, 0, 0, 100, 100, 1));         // drops pending
      wait_idle();

      // Nominal limits, short confirm times
      load_limits(16'sd650, 16'sd600, 16'sd550, 16'sd450, 16'sd0, 32'd60, 32'd120);
      run_scans(100, 1'b1);

      // Extremes, one way
      load_limits(16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh8000,
                  32'd0, 32'hFFFF_FFFF);
      run_scans(60, 1'b0);

      // Extremes, the other way
      load_limits(16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh7FFF,
                  32'hFFFF_FFFF, 32'd0);
      run_scans(40, 1'b0);

      // Arbitrary limits in any order
      load_limits(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                  16'($urandom), $urandom_range(0, 300), $urandom_range(0, 300));
      run_scans(100, 1'b1);

      // Compressed band of limits
      load_limits(16'sd300, 16'sd200, 16'sd100, 16'sd0, -16'sd100,
                  $urandom_range(0, 150), $urandom_range(0, 150));
      run_scans(100, 1'b0);

      wait_idle();
      repeat (10) @(posedge clock);
      if (fail_count == 0) begin
         $display("** battery_temperature_fault_policy_core: PASSED **");
      end else begin
         $display("** battery_temperature_fault_policy_core: FAILED **");
      end
      $finish;
   end

endmodule

// ===== files.f =====
design/btfp_pkg.sv
design/btfp_if.sv
design/btfp_csr.sv
design/btfp_eval.sv
design/battery_temperature_fault_policy_core.sv
dv/battery_temperature_fault_policy_core_test.sv
